FILE: design/pdq_pkg.sv
// ----------------------------------------------------------------------------
// pdq_pkg
// shared types and codes for the process id deque with removal
// ----------------------------------------------------------------------------
package pdq_pkg;

  // operation selector carried on the input channel
  typedef enum logic [1:0] {
    M_APPEND    = 2'd0,
    M_TAKE_HEAD = 2'd1,
    M_TAKE_TAIL = 2'd2,
    M_REMOVE    = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_ERROR = 2'd2
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_TAKE,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIN
  } state_t;

  // memory read address source
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_TAIL,
    RD_NEXT
  } rd_sel_t;

  // result id source
  typedef enum logic [1:0] {
    ID_ZERO,
    ID_PID,
    ID_RDATA
  } id_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      latch;
    logic      wr_append;
    logic      head_adv;
    logic      dec_count;
    logic      scan_start;
    logic      step;
    logic      shift_wr;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      res_en;
    status_t   res_status;
    id_sel_t   res_id;
    logic      out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  empty;
    logic  full;
    logic  bad;
    logic  match;
    logic  last;
    logic  out_free;
  } stat_t;

endpackage

FILE: design/pdq_ctrl.sv
// ----------------------------------------------------------------------------
// pdq_ctrl
// operation sequencer: decides, scans, closes gaps and hands off results
// ----------------------------------------------------------------------------
module pdq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  pdq_pkg::stat_t stat,
  output pdq_pkg::cmd_t  cmd
);
  import pdq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        unique case (stat.mode)
          M_APPEND: state_nxt = S_FIN;
          M_TAKE_HEAD,
          M_TAKE_TAIL: state_nxt = stat.empty ? S_FIN : S_TAKE;
          M_REMOVE: state_nxt = (stat.empty || stat.bad) ? S_FIN : S_SCAN;
          default: state_nxt = S_FIN;
        endcase
      end
      S_TAKE: state_nxt = S_FIN;
      S_SCAN: begin
        priority if (stat.match) state_nxt = S_SHIFT_RD;
        else if (stat.last)      state_nxt = S_FIN;
        else                     state_nxt = S_SCAN;
      end
      S_SHIFT_RD: state_nxt = stat.last ? S_FIN : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_FIN: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      S_EVAL: begin
        unique case (stat.mode)
          M_APPEND: begin
            cmd.res_en = 1'b1;
            if (stat.full || stat.bad) begin
              cmd.res_status = STAT_ERROR;
              cmd.res_id     = ID_ZERO;
            end else begin
              cmd.wr_append  = 1'b1;
              cmd.res_status = STAT_OK;
              cmd.res_id     = ID_PID;
            end
          end
          M_TAKE_HEAD,
          M_TAKE_TAIL: begin
            if (stat.empty) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = STAT_EMPTY;
              cmd.res_id     = ID_ZERO;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = (stat.mode == M_TAKE_HEAD) ? RD_HEAD : RD_TAIL;
            end
          end
          M_REMOVE: begin
            priority if (stat.empty) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = STAT_EMPTY;
              cmd.res_id     = ID_ZERO;
            end else if (stat.bad) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = STAT_ERROR;
              cmd.res_id     = ID_ZERO;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.rd_en      = 1'b1;
              cmd.rd_sel     = RD_HEAD;
            end
          end
          default: begin
            cmd.res_en     = 1'b1;
            cmd.res_status = STAT_ERROR;
            cmd.res_id     = ID_ZERO;
          end
        endcase
      end
      S_TAKE: begin
        cmd.res_en     = 1'b1;
        cmd.res_status = STAT_OK;
        cmd.res_id     = ID_RDATA;
        cmd.dec_count  = 1'b1;
        cmd.head_adv   = (stat.mode == M_TAKE_HEAD);
      end
      S_SCAN: begin
        priority if (stat.match) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = STAT_OK;
          cmd.res_id     = ID_PID;
        end else if (stat.last) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = STAT_ERROR;
          cmd.res_id     = ID_ZERO;
        end else begin
          cmd.step   = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_SHIFT_RD: begin
        if (stat.last) begin
          cmd.dec_count = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.step     = 1'b1;
      end
      S_FIN: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: design/pdq_dpath.sv
// ----------------------------------------------------------------------------
// pdq_dpath
// circular slot memory, head pointer, count, scan pointer and result register
// ----------------------------------------------------------------------------
module pdq_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     in_mode,
  input  logic [7:0]     in_proc_id,
  input  logic           in_proc_live,
  input  pdq_pkg::cmd_t  cmd,
  output pdq_pkg::stat_t stat,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_id,
  output logic [1:0]     out_status,
  output logic [6:0]     out_count,
  output logic           out_is_empty,
  output logic           out_is_full
);
  import pdq_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);
  localparam logic [SUM_W-1:0] CAP_SUM   = SUM_W'(CAPACITY);
  localparam logic [8:0]       CAP_ID    = 9'(CAPACITY);

  logic [7:0] mem [CAPACITY];
  logic [7:0] rdata_r;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;

  mode_t      op_mode_r;
  logic [7:0] op_pid_r;
  logic       op_bad_r;

  logic [7:0] res_id_r;
  status_t    res_status_r;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_id_r;
  status_t    out_status_r;
  logic [6:0] out_count_r;
  logic       out_empty_r;
  logic       out_full_r;

  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] ptr_inc;
  logic [SUM_W-1:0] app_sum, tail_sum;
  logic [IDX_W-1:0] app_addr, tail_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [CNT_W+6:0] count_ext;

  // wrap-around increments
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign ptr_inc  = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;

  // physical slot after the last entry, and of the last entry
  assign app_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_sum = app_sum - 1'b1;
  always_comb begin
    app_addr  = (app_sum >= CAP_SUM) ? IDX_W'(app_sum - CAP_SUM) : IDX_W'(app_sum);
    tail_addr = (tail_sum >= CAP_SUM) ? IDX_W'(tail_sum - CAP_SUM) : IDX_W'(tail_sum);
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_HEAD: rd_addr = head_r;
      RD_TAIL: rd_addr = tail_addr;
      RD_NEXT: rd_addr = ptr_inc;
      default: rd_addr = head_r;
    endcase
  end

  assign mem_we  = cmd.wr_append | cmd.shift_wr;
  assign wr_addr = cmd.wr_append ? app_addr : ptr_r;
  assign wr_data = cmd.wr_append ? op_pid_r : rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata_r <= mem[rd_addr];
  end

  // pointers and count
  always_comb begin
    head_nxt  = cmd.head_adv ? head_inc : head_r;
    count_nxt = count_r;
    if (cmd.wr_append) count_nxt = count_r + 1'b1;
    else if (cmd.dec_count) count_nxt = count_r - 1'b1;
    idx_nxt = idx_r;
    ptr_nxt = ptr_r;
    if (cmd.scan_start) begin
      idx_nxt = '0;
      ptr_nxt = head_r;
    end else if (cmd.step) begin
      idx_nxt = idx_r + 1'b1;
      ptr_nxt = ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    ptr_r <= ptr_nxt;
  end

  // operation capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_mode_r <= mode_t'(in_mode);
      op_pid_r  <= in_proc_id;
      op_bad_r  <= ({1'b0, in_proc_id} >= CAP_ID) | ~in_proc_live;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      res_status_r <= cmd.res_status;
      unique case (cmd.res_id)
        ID_ZERO:  res_id_r <= '0;
        ID_PID:   res_id_r <= op_pid_r;
        ID_RDATA: res_id_r <= rdata_r;
        default:  res_id_r <= '0;
      endcase
    end
  end

  // output register
  assign count_ext = {7'd0, count_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_id_r     <= res_id_r;
      out_status_r <= res_status_r;
      out_count_r  <= count_ext[6:0];
      out_empty_r  <= (count_r == '0);
      out_full_r   <= (count_r == CAP_CNT);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_id       = out_id_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_is_empty = out_empty_r;
  assign out_is_full  = out_full_r;

  // status to controller
  assign stat.mode     = op_mode_r;
  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r >= CAP_CNT);
  assign stat.bad      = op_bad_r;
  assign stat.match    = (rdata_r == op_pid_r);
  assign stat.last     = ((idx_r + 1'b1) == count_r);
  assign stat.out_free = ~out_valid_r | out_tready;

endmodule

FILE: design/process_id_deque_with_removal_unit.sv
// ----------------------------------------------------------------------------
// process_id_deque_with_removal_unit
// bounded ordered queue of process ids with head/tail takes and removal by id
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in_     | slave     | in_tvalid / in_tready | tuser mode, tdata id and live
//  out_    | master    | out_tvalid/out_tready | tuser status, tdata id, count,
//          |           |                       | empty and full flags
//
//  the slot memory has a single read and a single write port, so a removal
//  scans one entry per scan step and closes the gap with one read state
//  and one write state per entry moved toward the head
//  synchronous reset clears count and head pointer; slot contents are not cleared
//  a result waits in the output register; the next transfer is taken
//  meanwhile and its result is held until the output register frees up
//
module process_id_deque_with_removal_unit #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] mode
  input  logic [15:0] in_tdata,   // [7:0] proc_id, [8] proc_live, [15:9] zero
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [23:0] out_tdata   // [7:0] out_id, [14:8] count, [15] is_empty,
                                  // [16] is_full, [23:17] zero
);
  import pdq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic [7:0] res_id;
  logic [1:0] res_status;
  logic [6:0] res_count;
  logic       res_empty;
  logic       res_full;

  // sequencer: one operation in flight at a time
  pdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slot memory kept as a ring: head pointer plus count, removal closes
  // the gap by moving later entries one slot toward the head
  pdq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mode      (in_tuser),
    .in_proc_id   (in_tdata[7:0]),
    .in_proc_live (in_tdata[8]),
    .cmd          (cmd),
    .stat         (stat),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_id       (res_id),
    .out_status   (res_status),
    .out_count    (res_count),
    .out_is_empty (res_empty),
    .out_is_full  (res_full)
  );

  // pack the result transfer
  assign out_tuser = res_status;
  assign out_tdata = {7'd0, res_full, res_empty, res_count, res_id};

endmodule
